### sv/tphg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tphg_pkg
// Shared types and fixed constants of the touch press/hold gesture block.
// ----------------------------------------------------------------------------
package tphg_pkg;

  // Gesture event codes carried in the result.
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_PRESS = 2'd1,
    EV_HOLD  = 2'd2
  } event_t;

  // Configuration register indexes (byte address = 4 * index).
  typedef enum logic [2:0] {
    REG_PCT     = 3'd0,
    REG_PDEB    = 3'd1,
    REG_RDEB    = 3'd2,
    REG_HOLD    = 3'd3,
    REG_REP_EN  = 3'd4,
    REG_REP_IVL = 3'd5
  } reg_idx_t;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned MS_W     = 16;

  // floor(x / 100) = (x * PCT_MUL) >> PCT_SHIFT for x < 2^23 (baseline * pct).
  // The percent factor is folded in: k = pct * PCT_MUL.
  localparam int unsigned PCT_SHIFT = 30;
  localparam int unsigned PCT_MAX   = 100;
  localparam int unsigned K_W       = 31;
  localparam logic [23:0] PCT_MUL   = 24'd10737419;

  localparam logic [PCT_W-1:0] PCT_RST  = 7'd20;
  localparam logic [K_W-1:0]   K_RST    = 31'd214748380;
  localparam logic [MS_W-1:0]  PDEB_RST = 16'd50;
  localparam logic [MS_W-1:0]  RDEB_RST = 16'd50;
  localparam logic [MS_W-1:0]  HOLD_RST = 16'd1000;
  localparam logic [MS_W-1:0]  IVL_RST  = 16'd200;

  // Timing settings seen by the gesture machine.
  typedef struct packed {
    logic [MS_W-1:0] press_deb;
    logic [MS_W-1:0] rel_deb;
    logic [MS_W-1:0] hold;
    logic            rep_en;
    logic [MS_W-1:0] rep_ivl;
  } gest_cfg_t;

endpackage
`default_nettype wire

### sv/tphg_gesture.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tphg_gesture
// Press debounce / short press / hold with repeat / release debounce machine.
// ----------------------------------------------------------------------------
module tphg_gesture (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              step,     // sensing sample taken
  input  wire                              pressed,
  input  wire [tphg_pkg::TIME_W-1:0]       now_ms,
  input  tphg_pkg::gest_cfg_t              cfg,
  output tphg_pkg::event_t                 ev
);

  localparam logic [1:0] PH_WAIT_PRESS   = 2'd0;
  localparam logic [1:0] PH_DEB_PRESS    = 2'd1;
  localparam logic [1:0] PH_WAIT_RELEASE = 2'd2;
  localparam logic [1:0] PH_DEB_RELEASE  = 2'd3;

  logic [1:0]                  phase_r, phase_nxt;
  logic [tphg_pkg::TIME_W-1:0] press_start_r, press_start_nxt;
  logic [tphg_pkg::TIME_W-1:0] release_time_r, release_time_nxt;
  logic [tphg_pkg::TIME_W-1:0] last_hold_r, last_hold_nxt;
  logic                        hold_fired_r, hold_fired_nxt;

  logic [tphg_pkg::TIME_W-1:0] held;
  logic [tphg_pkg::TIME_W-1:0] since_rel;
  logic [tphg_pkg::TIME_W-1:0] since_hold;

  // all time differences wrap modulo 2^32
  assign held       = now_ms - press_start_r;
  assign since_rel  = now_ms - release_time_r;
  assign since_hold = now_ms - last_hold_r;

  always_comb begin
    phase_nxt        = phase_r;
    press_start_nxt  = press_start_r;
    release_time_nxt = release_time_r;
    last_hold_nxt    = last_hold_r;
    hold_fired_nxt   = hold_fired_r;
    ev               = tphg_pkg::EV_NONE;
    case (phase_r)
      PH_WAIT_PRESS: begin
        if (pressed) begin
          press_start_nxt = now_ms;
          phase_nxt       = PH_DEB_PRESS;
        end
      end
      PH_DEB_PRESS: begin
        if (held > tphg_pkg::TIME_W'(cfg.press_deb)) begin
          phase_nxt = pressed ? PH_WAIT_RELEASE : PH_WAIT_PRESS;
        end
      end
      PH_WAIT_RELEASE: begin
        if (!pressed) begin
          hold_fired_nxt = 1'b0;
          if (held < tphg_pkg::TIME_W'(cfg.hold)) begin
            release_time_nxt = now_ms;
            phase_nxt        = PH_DEB_RELEASE;
            ev               = tphg_pkg::EV_PRESS;
          end else begin
            // long press let go: no event
            phase_nxt = PH_WAIT_PRESS;
          end
        end else if (held > tphg_pkg::TIME_W'(cfg.hold)) begin
          if (!hold_fired_r) begin
            hold_fired_nxt = 1'b1;
            last_hold_nxt  = now_ms;
            ev             = tphg_pkg::EV_HOLD;
          end else if (cfg.rep_en && (since_hold >= tphg_pkg::TIME_W'(cfg.rep_ivl))) begin
            last_hold_nxt = now_ms;
            ev            = tphg_pkg::EV_HOLD;
          end
        end
      end
      PH_DEB_RELEASE: begin
        if (since_rel > tphg_pkg::TIME_W'(cfg.rel_deb)) begin
          phase_nxt      = PH_WAIT_PRESS;
          hold_fired_nxt = 1'b0;
        end
      end
      default: begin
        phase_nxt = PH_WAIT_PRESS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_WAIT_PRESS;
      press_start_r  <= '0;
      release_time_r <= '0;
      last_hold_r    <= '0;
      hold_fired_r   <= 1'b0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      press_start_r  <= press_start_nxt;
      release_time_r <= release_time_nxt;
      last_hold_r    <= last_hold_nxt;
      hold_fired_r   <= hold_fired_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/touch_press_hold_gesture_fsm_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_press_hold_gesture_fsm_top
// Touch sample classifier, press/hold gesture machine and baseline calibration.
// ----------------------------------------------------------------------------
// Output: a result is registered and is on out_* in the cycle after its input
//   transfer; an item that completes a calibration round waits in out_wait_r first.
// Throughput: one item per cycle unless the result side stalls. The threshold
//   register is rebuilt from the baseline by one multiplier, so in_tready is held
//   low by thr_pend_r after a round completes and after a write to the percent register.
// Reset: rst_n synchronous, active low; registers return to their defaults,
//   baseline and threshold to zero, gesture machine to waiting for a press.
// ----------------------------------------------------------------------------
module touch_press_hold_gesture_fsm_top #(
  parameter int unsigned CALIB_SAMPLES = 5   // 1..7
) (
  input  wire         clk,
  input  wire         rst_n,
  // input channel
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,     // [15:0] sample, [47:16] now_ms
  input  wire         in_tuser,     // [0] command: 0 sensing, 1 calibration
  // result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,    // [1:0] event_res, [2] calibrated,
                                    // [18:3] threshold, [23:19] zero
  // configuration
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [4:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned SW = tphg_pkg::SAMPLE_W;

  // Calibration accumulator: CALIB_SAMPLES samples of 16 bits.
  localparam int unsigned CNT_W = $clog2(CALIB_SAMPLES + 1);
  localparam int unsigned SUM_W = SW + CNT_W;

  // Mean by reciprocal: exact for sums below 2^SUM_W since the rounding
  // error of DIV_MUL stays below 2^clog2(CALIB_SAMPLES).
  localparam int unsigned DIV_SHIFT = SUM_W + $clog2(CALIB_SAMPLES);
  localparam int unsigned DIV_MUL_W = DIV_SHIFT + 1;
  localparam longint unsigned DIV_MUL_L =
    ((64'd1 << DIV_SHIFT) + CALIB_SAMPLES - 1) / CALIB_SAMPLES;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_W'(DIV_MUL_L);
  localparam int unsigned DIV_PROD_W = SUM_W + DIV_MUL_W;

  localparam int unsigned THR_PROD_W = SW + tphg_pkg::K_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [tphg_pkg::PCT_W-1:0] pct_r;
  logic [tphg_pkg::K_W-1:0]   k_r;        // clamped percent * PCT_MUL
  logic [tphg_pkg::MS_W-1:0]  pdeb_r, rdeb_r, hold_r, ivl_r;
  logic                       rep_en_r;

  logic                       cfg_wr;
  tphg_pkg::reg_idx_t         cfg_idx;
  logic [tphg_pkg::PCT_W-1:0] pct_clamp;
  logic [tphg_pkg::K_W-1:0]   k_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = tphg_pkg::reg_idx_t'(cfg_paddr[4:2]);

  // percent above 100 acts as 100 (threshold becomes zero)
  assign pct_clamp = (cfg_pwdata[6:0] > tphg_pkg::PCT_W'(tphg_pkg::PCT_MAX)) ?
                     tphg_pkg::PCT_W'(tphg_pkg::PCT_MAX) : cfg_pwdata[6:0];
  assign k_nxt     = tphg_pkg::K_W'(pct_clamp) * tphg_pkg::K_W'(tphg_pkg::PCT_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r    <= tphg_pkg::PCT_RST;
      k_r      <= tphg_pkg::K_RST;
      pdeb_r   <= tphg_pkg::PDEB_RST;
      rdeb_r   <= tphg_pkg::RDEB_RST;
      hold_r   <= tphg_pkg::HOLD_RST;
      rep_en_r <= 1'b0;
      ivl_r    <= tphg_pkg::IVL_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tphg_pkg::REG_PCT: begin
          pct_r <= cfg_pwdata[6:0];
          k_r   <= k_nxt;
        end
        tphg_pkg::REG_PDEB:    pdeb_r   <= cfg_pwdata[15:0];
        tphg_pkg::REG_RDEB:    rdeb_r   <= cfg_pwdata[15:0];
        tphg_pkg::REG_HOLD:    hold_r   <= cfg_pwdata[15:0];
        tphg_pkg::REG_REP_EN:  rep_en_r <= cfg_pwdata[0];
        tphg_pkg::REG_REP_IVL: ivl_r    <= cfg_pwdata[15:0];
        default: ;                        // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      tphg_pkg::REG_PCT:     cfg_prdata = 32'(pct_r);
      tphg_pkg::REG_PDEB:    cfg_prdata = 32'(pdeb_r);
      tphg_pkg::REG_RDEB:    cfg_prdata = 32'(rdeb_r);
      tphg_pkg::REG_HOLD:    cfg_prdata = 32'(hold_r);
      tphg_pkg::REG_REP_EN:  cfg_prdata = 32'(rep_en_r);
      tphg_pkg::REG_REP_IVL: cfg_prdata = 32'(ivl_r);
      default:               cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input unpack and handshake
  // --------------------------------------------------------------------------
  logic [SW-1:0]                in_sample;
  logic [tphg_pkg::TIME_W-1:0]  in_now;
  logic                         in_acc;
  logic                         thr_pend_r;  // threshold being rebuilt
  logic                         out_wait_r;  // result waits on new threshold
  logic                         out_valid_r;

  assign in_sample = in_tdata[15:0];
  assign in_now    = in_tdata[47:16];

  // result register parts the two sides; hold off while threshold settles
  assign in_tready = !thr_pend_r && !out_wait_r && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // Baseline, calibration and threshold
  // --------------------------------------------------------------------------
  logic [SW-1:0]         baseline_r;
  logic [SW-1:0]         thr_r, thr_nxt;
  logic [SUM_W-1:0]      sum_r, sum_add;
  logic [CNT_W-1:0]      cnt_r, cnt_add;
  logic                  cal_done;
  logic [DIV_PROD_W-1:0] div_prod;
  logic [THR_PROD_W-1:0] thr_prod;

  assign sum_add  = sum_r + SUM_W'(in_sample);
  assign cnt_add  = cnt_r + CNT_W'(1);
  assign cal_done = in_tuser && (cnt_add >= CNT_W'(CALIB_SAMPLES));
  assign div_prod = DIV_PROD_W'(sum_add) * DIV_PROD_W'(DIV_MUL);

  // threshold = baseline - floor(baseline * pct / 100)
  assign thr_prod = THR_PROD_W'(baseline_r) * THR_PROD_W'(k_r);
  assign thr_nxt  = baseline_r - thr_prod[tphg_pkg::PCT_SHIFT +: SW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      baseline_r <= '0;
      sum_r      <= '0;
      cnt_r      <= '0;
      thr_r      <= '0;
    end else begin
      thr_r <= thr_nxt;
      if (in_acc && in_tuser) begin
        if (cal_done) begin
          baseline_r <= div_prod[DIV_SHIFT +: SW];
          sum_r      <= '0;
          cnt_r      <= '0;
        end else begin
          sum_r <= sum_add;
          cnt_r <= cnt_add;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Press detect and gesture machine
  // --------------------------------------------------------------------------
  logic signed [SW:0] diff;
  logic               pressed;
  tphg_pkg::event_t   ev;
  tphg_pkg::gest_cfg_t gcfg;

  assign diff    = $signed({1'b0, baseline_r}) - $signed({1'b0, in_sample});
  assign pressed = diff > $signed({1'b0, thr_r});

  assign gcfg.press_deb = pdeb_r;
  assign gcfg.rel_deb   = rdeb_r;
  assign gcfg.hold      = hold_r;
  assign gcfg.rep_en    = rep_en_r;
  assign gcfg.rep_ivl   = ivl_r;

  tphg_gesture u_gesture (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_acc && !in_tuser),
    .pressed (pressed),
    .now_ms  (in_now),
    .cfg     (gcfg),
    .ev      (ev)
  );

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  tphg_pkg::event_t out_ev_r;
  logic             out_cal_r;
  logic [SW-1:0]    out_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_wait_r  <= 1'b0;
      thr_pend_r  <= 1'b0;
    end else begin
      thr_pend_r <= (in_acc && cal_done) || (cfg_wr && (cfg_idx == tphg_pkg::REG_PCT));
      if (out_wait_r) begin
        // new baseline has gone through the multiplier
        out_valid_r <= 1'b1;
        out_wait_r  <= 1'b0;
      end else if (in_acc) begin
        out_valid_r <= !cal_done;
        out_wait_r  <= cal_done;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_wait_r) begin
      out_thr_r <= thr_nxt;
    end else if (in_acc) begin
      out_ev_r  <= in_tuser ? tphg_pkg::EV_NONE : ev;
      out_cal_r <= cal_done;
      out_thr_r <= thr_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_thr_r, out_cal_r, out_ev_r};

endmodule
`default_nettype wire

### sv/tphg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tphg_checker
// Port-level checks of the touch gesture block, bound to the top level.
// ----------------------------------------------------------------------------
module tphg_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        in_tuser,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [23:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no new transfer while a stalled result occupies the output register
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken over a stalled result");

  // a sensing sample gives its result on the next cycle
  a_sense_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> out_tvalid)
    else $error("sensing result missing");

  // a calibration round result never carries a gesture event
  a_cal_no_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1:0] == tphg_pkg::EV_NONE)
    else $error("event on calibration result");

endmodule

bind touch_press_hold_gesture_fsm_top tphg_checker u_tphg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

### tb/sv/touch_press_hold_gesture_fsm_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_press_hold_gesture_fsm_top_test
// Self-checking bench for the touch press/hold gesture block: a directed
// sequence, then randomized press/release gestures, calibration rounds and
// noise across several register settings, with idle gaps on both streams.
// ----------------------------------------------------------------------------
module touch_press_hold_gesture_fsm_top_test;
  import tphg_pkg::*;

  localparam int unsigned CAL_ROUND    = 5;           // samples per calibration round
  localparam int unsigned REG_COUNT    = 6;
  localparam int unsigned UNUSED_IDX_A = 6;           // byte address 24, no register
  localparam int unsigned UNUSED_IDX_B = 7;           // byte address 28, no register
  localparam int unsigned MAX_REPORTS  = 200;         // cap on printed mismatch lines
  localparam int unsigned LIMIT_NS     = 20_000_000;  // in ns, far above a slow run
  localparam int unsigned PHASE_ITEMS  = 178;         // random items per register setting
  localparam int unsigned SETTINGS_N   = 7;

  // gesture machine phases as the block sees them
  typedef enum bit [1:0] {
    WAIT_PRESS = 2'd0,
    DEB_PRESS  = 2'd1,
    WAIT_REL   = 2'd2,
    DEB_REL    = 2'd3
  } gest_phase_t;

  typedef struct packed {
    event_t      ev;
    logic        cal;
    logic [15:0] thr;
  } gesture_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of registers and machine state, predicts one result
  // per accepted sample and checks results in order.
  // --------------------------------------------------------------------------
  class gesture_scoreboard;
    bit [PCT_W-1:0]  pct;
    bit [MS_W-1:0]   press_deb_ms;
    bit [MS_W-1:0]   rel_deb_ms;
    bit [MS_W-1:0]   hold_ms;
    bit              rep_on;
    bit [MS_W-1:0]   rep_ivl_ms;

    gest_phase_t     phase;
    bit [31:0]       press_start;
    bit [31:0]       release_time;
    bit [31:0]       last_hold;
    bit              hold_fired;
    bit [15:0]       baseline;
    bit [18:0]       cal_sum;
    bit [2:0]        cal_cnt;

    gesture_result_t pending_results[$];
    int unsigned     errors;

    function new();
      pct          = 20;
      press_deb_ms = 50;
      rel_deb_ms   = 50;
      hold_ms      = 1000;
      rep_on       = 0;
      rep_ivl_ms   = 200;
      phase        = WAIT_PRESS;
      press_start  = 0;
      release_time = 0;
      last_hold    = 0;
      hold_fired   = 0;
      baseline     = 0;
      cal_sum      = 0;
      cal_cnt      = 0;
      errors       = 0;
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void set_reg(int unsigned idx, bit [31:0] v);
      case (idx)
        REG_PCT:     pct          = v[PCT_W-1:0];
        REG_PDEB:    press_deb_ms = v[MS_W-1:0];
        REG_RDEB:    rel_deb_ms   = v[MS_W-1:0];
        REG_HOLD:    hold_ms      = v[MS_W-1:0];
        REG_REP_EN:  rep_on       = v[0];
        REG_REP_IVL: rep_ivl_ms   = v[MS_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [31:0] reg_value(int unsigned idx);
      case (idx)
        REG_PCT:     return 32'(pct);
        REG_PDEB:    return 32'(press_deb_ms);
        REG_RDEB:    return 32'(rel_deb_ms);
        REG_HOLD:    return 32'(hold_ms);
        REG_REP_EN:  return 32'(rep_on);
        REG_REP_IVL: return 32'(rep_ivl_ms);
        default:     return 32'd0;
      endcase
    endfunction

    // baseline - baseline*pct/100, pct saturating at 100
    function bit [15:0] threshold_now();
      int unsigned p;
      int unsigned b;
      p = (pct > PCT_MAX) ? PCT_MAX : pct;
      b = baseline;
      return 16'(b - (b * p) / PCT_MAX);
    endfunction

    // samples below this level count as pressed
    function int press_edge();
      return int'(baseline) - int'(threshold_now());
    endfunction

    function bit calib_step(bit [15:0] sample);
      cal_sum = cal_sum + sample;
      cal_cnt = cal_cnt + 3'd1;
      if (cal_cnt >= CAL_ROUND) begin
        baseline = 16'(cal_sum / CAL_ROUND);
        cal_sum  = 0;
        cal_cnt  = 0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function event_t sense_step(bit [15:0] sample, bit [31:0] now);
      int        diff;
      int        thr;
      bit        pressed;
      bit [31:0] held;
      diff    = baseline - sample;   // 32-bit wrap gives the signed difference
      thr     = threshold_now();
      pressed = diff > thr;
      held    = now - press_start;
      case (phase)
        WAIT_PRESS: begin
          if (pressed) begin
            press_start = now;
            phase       = DEB_PRESS;
          end
        end
        DEB_PRESS: begin
          if (held > press_deb_ms) phase = pressed ? WAIT_REL : WAIT_PRESS;
        end
        WAIT_REL: begin
          if (!pressed) begin
            hold_fired = 0;
            if (held < hold_ms) begin
              release_time = now;
              phase        = DEB_REL;
              return EV_PRESS;
            end
            phase = WAIT_PRESS;   // long press let go: silent
          end else if (held > hold_ms) begin
            if (!hold_fired) begin
              hold_fired = 1;
              last_hold  = now;
              return EV_HOLD;
            end
            if (rep_on && (now - last_hold) >= rep_ivl_ms) begin
              last_hold = now;
              return EV_HOLD;
            end
          end
        end
        default: begin
          if (now - release_time > rel_deb_ms) begin
            phase      = WAIT_PRESS;
            hold_fired = 0;
          end
        end
      endcase
      return EV_NONE;
    endfunction

    function void note_sample(bit cmd, bit [15:0] sample, bit [31:0] now);
      gesture_result_t r;
      r.ev  = EV_NONE;
      r.cal = 1'b0;
      if (cmd) r.cal = calib_step(sample);
      else     r.ev  = sense_step(sample, now);
      r.thr = threshold_now();
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [23:0] data);
      gesture_result_t want;
      if (pending_results.size() == 0) begin
        fail($sformatf("result with nothing expected: tdata=%h", data));
        return;
      end
      want = pending_results.pop_front();
      if (data[1:0] !== want.ev || data[2] !== want.cal || data[18:3] !== want.thr ||
          data[23:19] !== 5'd0)
        fail($sformatf({"result mismatch: expected event=%0d calibrated=%0b threshold=%0d,",
                        " actual event=%0d calibrated=%0b threshold=%0d pad=%h"},
                       want.ev, want.cal, want.thr,
                       data[1:0], data[2], data[18:3], data[23:19]));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata    = '0;   // [15:0] sample, [47:16] now_ms
  logic        in_tuser    = 1'b0; // [0] command
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [23:0] out_tdata;          // [1:0] event, [2] calibrated, [18:3] threshold
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [4:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  touch_press_hold_gesture_fsm_top #(
    .CALIB_SAMPLES(CAL_ROUND)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  gesture_scoreboard sb = new();

  int unsigned in_idle_mode   = 1;  // 0: back to back, 1: random gaps
  int unsigned out_idle_mode  = 1;
  int unsigned out_stall_left = 0;
  int unsigned items_sent     = 0;
  bit [31:0]   clock_ms;            // stimulus time base, wraps freely

  // Gap length: mostly none, some short, a few long.
  function automatic int unsigned idle_len(int unsigned mode);
    int unsigned r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned reg_width(int unsigned idx);
    case (idx)
      REG_PCT:    return PCT_W;
      REG_REP_EN: return 1;
      default:    return MS_W;
    endcase
  endfunction

  // result side back-pressure, one assignment per falling edge
  always @(negedge clk) begin
    if (out_stall_left != 0) begin
      out_tready <= 1'b0;
      out_stall_left--;
    end else begin
      out_tready <= 1'b1;
      out_stall_left = idle_len(out_idle_mode);
    end
  end

  // every result transfer goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // One input transfer; valid stays high into the next item when no gap is drawn.
  task automatic send_item(bit cmd, bit [15:0] sample, bit [31:0] now);
    int unsigned gap;
    gap = idle_len(in_idle_mode);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {now, sample};
    do @(posedge clk); while (!in_tready);
    sb.note_sample(cmd, sample, now);
    items_sent++;
  endtask

  // Stop input, let every expected result come back, then wait out the
  // calibration path and the threshold rebuild.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(int unsigned idx, bit [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 5'(idx * 4);
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // read back one register and compare with the scoreboard copy
  task automatic cfg_check(int unsigned idx);
    bit [31:0] got;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= 5'(idx * 4);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    if (got !== sb.reg_value(idx))
      sb.fail($sformatf("register %0d readback: expected %h, actual %h",
                        idx, sb.reg_value(idx), got));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Settings 0..3 are fixed corners, the rest random. Upper garbage bits
  // check the width masking; the unused addresses must not disturb anything.
  task automatic configure(int unsigned setting);
    bit [31:0] vals [REG_COUNT];
    case (setting)
      0: vals = '{20, 50, 50, 1000, 1, 200};
      1: vals = '{PCT_MAX, 0, 0, 0, 1, 0};
      2: vals = '{127, 65535, 65535, 65535, 1, 65535};  // percent saturates
      3: vals = '{0, 10, 10, 100, 0, 10};                // nothing can press
      default: begin
        vals[REG_PCT]     = $urandom_range(1, PCT_MAX);
        vals[REG_PDEB]    = $urandom_range(0, 200);
        vals[REG_RDEB]    = $urandom_range(0, 200);
        vals[REG_HOLD]    = $urandom_range(0, 3000);
        vals[REG_REP_EN]  = $urandom_range(0, 1);
        vals[REG_REP_IVL] = $urandom_range(0, 500);
      end
    endcase
    for (int i = 0; i < REG_COUNT; i++)
      cfg_write(i, vals[i] | ($urandom << reg_width(i)));
    cfg_write(UNUSED_IDX_A, $urandom);
    cfg_write(UNUSED_IDX_B, $urandom);
    for (int i = 0; i < REG_COUNT; i++) cfg_check(i);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus shaping
  // --------------------------------------------------------------------------
  // Pressed reading: below the press edge, sometimes right at edge-1.
  // With a zero edge (zero baseline or 0 percent) nothing presses.
  function automatic bit [15:0] press_sample();
    int e;
    e = sb.press_edge();
    if (e <= 0) return 16'($urandom);
    if ($urandom_range(0, 5) == 0) return 16'(e - 1);
    return 16'($urandom_range(0, e - 1));
  endfunction

  function automatic bit [15:0] release_sample();
    int e;
    e = sb.press_edge();
    if ($urandom_range(0, 5) == 0) return 16'(e);
    return 16'($urandom_range(e, 65535));
  endfunction

  // n calibration readings scattered around one random level
  task automatic calib_round(int unsigned n);
    int level;
    int s;
    level = $urandom_range(1500, 65535);
    for (int i = 0; i < n; i++) begin
      s = level + int'($urandom_range(0, 600)) - 300;
      if (s < 0) s = 0;
      if (s > 65535) s = 65535;
      send_item(1'b1, 16'(s), clock_ms);
      clock_ms += $urandom_range(0, 5);
    end
  endtask

  // Press for a span sized against the current timing registers, with an
  // occasional bounce, then a release tail sized against release debounce.
  task automatic run_gesture();
    int unsigned n_press;
    int unsigned n_rel;
    int unsigned span;
    int unsigned step;
    in_idle_mode  = ($urandom_range(0, 3) == 0) ? 0 : 1;
    out_idle_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
    n_press = $urandom_range(2, 12);
    case ($urandom_range(0, 3))
      0:       span = $urandom_range(0, 2 * sb.press_deb_ms + 4);
      1:       span = $urandom_range(sb.press_deb_ms, sb.press_deb_ms + sb.hold_ms + 4);
      2:       span = sb.hold_ms + $urandom_range(0, 4 * sb.rep_ivl_ms + 20);
      default: span = $urandom_range(0, 140000);
    endcase
    step = span / n_press;
    for (int i = 0; i < n_press; i++) begin
      send_item(1'b0, ($urandom_range(0, 9) == 0) ? release_sample() : press_sample(),
                clock_ms);
      clock_ms += step + $urandom_range(0, 2);
    end
    n_rel = $urandom_range(1, 5);
    span  = $urandom_range(0, 2 * sb.rel_deb_ms + 4);
    step  = span / n_rel;
    for (int i = 0; i < n_rel; i++) begin
      send_item(1'b0, release_sample(), clock_ms);
      clock_ms += step + $urandom_range(0, 2);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit [31:0]   t0;
    int unsigned phase_start;
    int unsigned pick;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values of every register
    for (int i = 0; i < REG_COUNT; i++) cfg_check(i);

    // Directed walk at reset timing (debounce 50, hold 1000, no repeat),
    // starting just below the 32-bit time wrap.
    t0 = 32'hFFFF_FF00;
    for (int i = 0; i < CAL_ROUND; i++)           // baseline 65535, threshold 52428
      send_item(1'b1, 16'hFFFF, (i == 0) ? 32'hFFFF_FFFF : 32'd0);
    send_item(1'b0, 16'hFFFF, t0);                // idle reading
    send_item(1'b0, 16'd0,    t0);                // press starts
    send_item(1'b0, 16'd13106, t0 + 51);          // just inside the edge: accepted
    send_item(1'b0, 16'd13107, t0 + 100);         // just outside: short press
    send_item(1'b0, 16'd0,    t0 + 120);          // ignored during release debounce
    send_item(1'b0, 16'd0,    t0 + 151);          // debounce over
    send_item(1'b0, 16'd0,    t0 + 152);          // second press
    send_item(1'b0, 16'd0,    t0 + 203);
    send_item(1'b0, 16'd0,    t0 + 1153);         // hold fires
    send_item(1'b0, 16'd0,    t0 + 1400);         // repeats off: quiet
    send_item(1'b0, 16'hFFFF, t0 + 1500);         // long press let go, no event
    send_item(1'b0, 16'd0,    t0 + 1501);         // bounce: press ...
    send_item(1'b0, 16'hFFFF, t0 + 1510);         // ... gone within debounce
    send_item(1'b0, 16'hFFFF, t0 + 1600);         // debounce rejects it
    for (int i = 0; i < CAL_ROUND; i++)           // baseline back to zero
      send_item(1'b1, 16'd0, t0 + 1700);

    // Random part: one register setting per stretch, each opened by a
    // calibration round (it may first close a round left partial) so presses can actually register.
    for (int s = 0; s < SETTINGS_N; s++) begin
      drain();
      configure(s);
      clock_ms    = (s == 2) ? 32'hFFFE_8000 : $urandom;
      phase_start = items_sent;
      calib_round(CAL_ROUND);
      while (items_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
          // full round, or a partial one that carries over
          calib_round(($urandom_range(0, 2) == 0) ? $urandom_range(1, CAL_ROUND - 1)
                                                  : CAL_ROUND);
        end else if (pick < 4) begin
          send_item(1'($urandom_range(0, 1)), 16'($urandom), $urandom);
        end else begin
          run_gesture();
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### touch_press_hold_gesture_fsm_top.f
sv/tphg_pkg.sv
sv/tphg_gesture.sv
sv/touch_press_hold_gesture_fsm_top.sv
sv/tphg_checker.sv
tb/sv/touch_press_hold_gesture_fsm_top_test.sv
